// ===== hdl/khsi_pkg.sv =====
// Shared types and constants for the kinematic heading and speed integrator.
`default_nettype none
package khsi_pkg;
  localparam logic [2:0] MODE_STOPPED = 3'd0;
  localparam logic [2:0] MODE_TURNING = 3'd1;
  localparam logic [2:0] MODE_ACCEL   = 3'd2;
  localparam logic [2:0] MODE_DECEL   = 3'd3;
  localparam logic [2:0] MODE_MOVING  = 3'd4;

  localparam int CORDIC_ITERS = 28;
  localparam int CORDIC_FRAC  = 30;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic [2:0] REG_SPEED_LIMIT   = 3'd0;
  localparam logic [2:0] REG_SPEED_STEP    = 3'd1;
  localparam logic [2:0] REG_TIME_STEP     = 3'd2;
  localparam logic [2:0] REG_START_X       = 3'd3;
  localparam logic [2:0] REG_START_Y       = 3'd4;
  localparam logic [2:0] REG_START_HEADING = 3'd5;

  typedef struct packed {
    logic load;      // capture the input transaction
    logic trig_init; // set up the CORDIC from the new heading
    logic trig_step; // one CORDIC rotation
    logic mul_v;     // v = speed * time_step
    logic mul_x;     // cos * v
    logic mul_y;     // sin * v
    logic commit;    // update positions, elapsed and the output record
  } khsi_cmd_t;

  typedef struct packed {
    logic restart;
    logic trig_done;
  } khsi_sts_t;

  function automatic logic [33:0] atan_lut(input logic [4:0] i);
    logic [33:0] r;
    case (i)
      5'd0:  r = 34'h020000000; 5'd1:  r = 34'h012E4051E;
      5'd2:  r = 34'h009FB385B; 5'd3:  r = 34'h0051111D4;
      5'd4:  r = 34'h0028B0D43; 5'd5:  r = 34'h00145D7E1;
      5'd6:  r = 34'h000A2F61E; 5'd7:  r = 34'h000517C55;
      5'd8:  r = 34'h00028BE53; 5'd9:  r = 34'h000145F2F;
      5'd10: r = 34'h0000A2F98; 5'd11: r = 34'h0000517CC;
      5'd12: r = 34'h000028BE6; 5'd13: r = 34'h0000145F3;
      5'd14: r = 34'h00000A2FA; 5'd15: r = 34'h00000517D;
      5'd16: r = 34'h0000028BE; 5'd17: r = 34'h00000145F;
      5'd18: r = 34'h000000A30; 5'd19: r = 34'h000000518;
      5'd20: r = 34'h00000028C; 5'd21: r = 34'h000000146;
      5'd22: r = 34'h0000000A3; 5'd23: r = 34'h000000051;
      5'd24: r = 34'h000000029; 5'd25: r = 34'h000000014;
      5'd26: r = 34'h00000000A; 5'd27: r = 34'h000000005;
      default: r = 34'h0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

// ===== hdl/khsi_ctrl.sv =====
// Sequencer that steps the datapath through one tick.
`default_nettype none
module khsi_ctrl (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  input  khsi_pkg::khsi_sts_t sts,
  output khsi_pkg::khsi_cmd_t cmd
);
  import khsi_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INIT = 3'd1;
  localparam logic [2:0] S_ROT  = 3'd2;
  localparam logic [2:0] S_MULV = 3'd3;
  localparam logic [2:0] S_MULX = 3'd4;
  localparam logic [2:0] S_MULY = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       ovalid_r, ovalid_nxt;
  logic       take;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ovalid_r;
  assign take      = in_valid && in_ready;

  always_comb begin
    state_nxt  = state_r;
    ovalid_nxt = ovalid_r;
    cmd        = '0;
    if (ovalid_r && out_ready) ovalid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (take) begin
          cmd.load  = 1'b1;
          state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        if (sts.restart) begin
          state_nxt = S_DONE;
        end else begin
          cmd.trig_init = 1'b1;
          state_nxt     = S_ROT;
        end
      end
      S_ROT: begin
        cmd.trig_step = 1'b1;
        cmd.mul_v     = 1'b1;
        if (sts.trig_done) state_nxt = S_MULX;
      end
      S_MULV: state_nxt = S_MULX;
      S_MULX: begin
        cmd.mul_x = 1'b1;
        state_nxt = S_MULY;
      end
      S_MULY: begin
        cmd.mul_y = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // The output register must be free before the record is written.
        if (!ovalid_r || out_ready) begin
          cmd.commit = 1'b1;
          ovalid_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== hdl/khsi_dp.sv =====
// Datapath: vehicle state, CORDIC rotator, shared multiplier and output record.
`default_nettype none
module khsi_dp #(
  parameter int TRIG_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  khsi_pkg::khsi_cmd_t cmd,
  output khsi_pkg::khsi_sts_t sts,
  input  wire logic        in_restart,
  input  wire logic        in_has_command,
  input  wire logic [2:0]  in_mode,
  input  wire logic signed [15:0] in_turn_rate,
  input  wire logic [23:0] speed_limit,
  input  wire logic [23:0] speed_step,
  input  wire logic [15:0] time_step,
  input  wire logic [31:0] start_x,
  input  wire logic [31:0] start_y,
  input  wire logic [15:0] start_heading,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic [23:0]      out_speed_now,
  output logic [15:0]      out_heading_now,
  output logic [2:0]       out_mode_now,
  output logic [31:0]      out_elapsed
);
  import khsi_pkg::*;

  localparam int SH = CORDIC_FRAC - TRIG_BITS;
  localparam int TW = TRIG_BITS + 2;
  // Per-tick displacement v is at most 2^24, so 26 signed bits hold it.
  localparam int VW = 26;

  logic [31:0] px_r, py_r, elapsed_r;
  logic [23:0] speed_r;
  logic [15:0] heading_r;
  logic [2:0]  mode_r;
  logic signed [15:0] turn_r;
  logic        restart_r;

  logic signed [33:0] cx_r, cy_r, cz_r;
  logic [4:0]  it_r;
  logic        flip_r;
  logic signed [VW-1:0] v_r;
  logic signed [31:0] dx_r, dy_r;

  logic [2:0]  m_eff;
  logic signed [15:0] tr_eff;
  logic signed [32:0] hprod;
  logic [15:0] head_new;
  logic [24:0] acc_sum;
  logic [23:0] speed_new;
  logic [31:0] ang, angf;
  logic        flip;
  logic signed [33:0] sx, sy, fx, fy;
  logic signed [TW-1:0] cos_q, sin_q;
  logic signed [40:0] vprod;
  logic signed [TW+VW-1:0] pprod;
  logic signed [TW+VW-1:0] pround;
  logic [32:0] esum;

  assign sts.restart   = restart_r;
  assign sts.trig_done = (it_r == 5'(CORDIC_ITERS - 1));

  always_comb begin
    m_eff  = mode_r;
    tr_eff = turn_r;
    if (in_has_command) begin
      m_eff  = (in_mode <= MODE_MOVING) ? in_mode : MODE_STOPPED;
      tr_eff = in_turn_rate;
    end
    hprod     = tr_eff * $signed({1'b0, time_step}) + 33'sd32768;
    head_new  = heading_r;
    speed_new = speed_r;
    acc_sum   = {1'b0, speed_r} + {1'b0, speed_step};
    case (m_eff) inside
      MODE_TURNING, MODE_MOVING: head_new = heading_r + hprod[31:16];
      MODE_ACCEL: speed_new = (acc_sum > {1'b0, speed_limit}) ? speed_limit : acc_sum[23:0];
      MODE_DECEL: speed_new = (speed_r < speed_step) ? 24'd0 : speed_r - speed_step;
      default: ;
    endcase
  end

  // CORDIC setup folds the half plane around 90..270 degrees.
  always_comb begin
    ang  = {heading_r, 16'd0};
    flip = ((ang - 32'h4000_0000) < 32'h8000_0000);
    angf = flip ? ang - 32'h8000_0000 : ang;
  end

  always_comb begin
    sx = cx_r >>> it_r;
    sy = cy_r >>> it_r;
    fx = flip_r ? -cx_r : cx_r;
    fy = flip_r ? -cy_r : cy_r;
  end

  // Round half up to Q1.TRIG_BITS.
  logic signed [33:0] rc, rs;
  always_comb begin
    rc    = fx + (34'sd1 <<< (SH - 1));
    rs    = fy + (34'sd1 <<< (SH - 1));
    cos_q = TW'(rc >>> SH);
    sin_q = TW'(rs >>> SH);
  end

  assign vprod = $signed({17'd0, speed_r}) * $signed({25'd0, time_step});

  // One multiplier shared by the cos and sin terms.
  always_comb begin
    pprod  = (cmd.mul_x ? cos_q : sin_q) * v_r;
    pround = (pprod + ((TW+VW)'(1) <<< (TRIG_BITS - 1))) >>> TRIG_BITS;
  end

  assign esum = {1'b0, elapsed_r} + {17'd0, time_step};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      px_r      <= 32'd0;
      py_r      <= 32'd0;
      speed_r   <= 24'd655360;
      heading_r <= 16'd0;
      mode_r    <= MODE_MOVING;
      turn_r    <= 16'sd0;
      elapsed_r <= 32'd0;
      restart_r <= 1'b0;
      it_r      <= 5'd0;
    end else begin
      if (cmd.load) begin
        restart_r <= in_restart;
        if (in_restart) begin
          px_r      <= start_x;
          py_r      <= start_y;
          heading_r <= start_heading;
          speed_r   <= speed_limit;
          mode_r    <= MODE_MOVING;
          elapsed_r <= 32'd0;
        end else begin
          mode_r    <= m_eff;
          turn_r    <= tr_eff;
          heading_r <= head_new;
          speed_r   <= speed_new;
        end
      end
      if (cmd.trig_init) it_r <= 5'd0;
      else if (cmd.trig_step) it_r <= it_r + 5'd1;
      if (cmd.commit && !restart_r) begin
        px_r      <= px_r + dx_r;
        py_r      <= py_r + dy_r;
        elapsed_r <= esum[32] ? 32'hFFFF_FFFF : esum[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.trig_init) begin
      cx_r   <= CORDIC_GAIN;
      cy_r   <= 34'sd0;
      cz_r   <= $signed({{2{angf[31]}}, angf});
      flip_r <= flip;
    end else if (cmd.trig_step) begin
      if (!cz_r[33]) begin
        cx_r <= cx_r - sy;
        cy_r <= cy_r + sx;
        cz_r <= cz_r - $signed(atan_lut(it_r));
      end else begin
        cx_r <= cx_r + sy;
        cy_r <= cy_r - sx;
        cz_r <= cz_r + $signed(atan_lut(it_r));
      end
    end
    if (cmd.mul_v) v_r <= VW'((vprod + 41'sd32768) >>> 16);
    if (cmd.mul_x) dx_r <= pround[31:0];
    if (cmd.mul_y) dy_r <= pround[31:0];
    if (cmd.commit) begin
      out_pos_x       <= restart_r ? px_r : px_r + dx_r;
      out_pos_y       <= restart_r ? py_r : py_r + dy_r;
      out_speed_now   <= speed_r;
      out_heading_now <= heading_r;
      out_mode_now    <= mode_r;
      out_elapsed     <= restart_r ? 32'd0 : (esum[32] ? 32'hFFFF_FFFF : esum[31:0]);
    end
  end
endmodule
`default_nettype wire

// ===== hdl/kinematic_heading_speed_integrator_core.sv =====
// Top level: configuration registers, sequencer and datapath.
//
//  channel   direction  handshake           payload
//  in_*      input      in_valid/in_ready   restart, has_command, mode, turn_rate
//  out_*     output     out_valid/out_ready pos_x, pos_y, speed_now, heading_now,
//                                           mode_now, elapsed
//  cfg_*     input      APB access phase    six registers at 4*i
//
// A stepping tick runs the CORDIC setup, the 28 CORDIC rotations done one per cycle,
// two shared multiplies and commit; a restart tick goes straight to commit.
// rst_n is synchronous; it restores the register and state reset values.
// The result sits in an output register; a new transaction is taken once the
// previous record is committed, so a stalled output delays at most one tick.
`default_nettype none
module kinematic_heading_speed_integrator_core #(
  parameter int TRIG_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_restart,
  input  wire logic        in_has_command,
  input  wire logic [2:0]  in_mode,
  input  wire logic signed [15:0] in_turn_rate,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic [23:0]      out_speed_now,
  output logic [15:0]      out_heading_now,
  output logic [2:0]       out_mode_now,
  output logic [31:0]      out_elapsed,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import khsi_pkg::*;

  logic [23:0] speed_limit_r, speed_step_r;
  logic [15:0] time_step_r, start_heading_r;
  logic [31:0] start_x_r, start_y_r;
  logic [2:0]  reg_idx;
  logic        wr;

  khsi_cmd_t cmd;
  khsi_sts_t sts;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[4:2];
  assign wr         = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_limit_r   <= 24'd655360;
      speed_step_r    <= 24'd655;
      time_step_r     <= 16'd655;
      start_x_r       <= 32'd0;
      start_y_r       <= 32'd0;
      start_heading_r <= 16'd0;
    end else if (wr) begin
      case (reg_idx)
        REG_SPEED_LIMIT:   speed_limit_r   <= cfg_pwdata[23:0];
        REG_SPEED_STEP:    speed_step_r    <= cfg_pwdata[23:0];
        REG_TIME_STEP:     time_step_r     <= cfg_pwdata[15:0];
        REG_START_X:       start_x_r       <= cfg_pwdata;
        REG_START_Y:       start_y_r       <= cfg_pwdata;
        REG_START_HEADING: start_heading_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SPEED_LIMIT:   cfg_prdata = {8'd0, speed_limit_r};
      REG_SPEED_STEP:    cfg_prdata = {8'd0, speed_step_r};
      REG_TIME_STEP:     cfg_prdata = {16'd0, time_step_r};
      REG_START_X:       cfg_prdata = start_x_r;
      REG_START_Y:       cfg_prdata = start_y_r;
      REG_START_HEADING: cfg_prdata = {16'd0, start_heading_r};
      default:           cfg_prdata = 32'd0;
    endcase
  end

  khsi_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
    .sts(sts), .cmd(cmd)
  );

  khsi_dp #(.TRIG_BITS(TRIG_BITS)) u_dp (
    .clk, .rst_n, .cmd(cmd), .sts(sts),
    .in_restart, .in_has_command, .in_mode, .in_turn_rate,
    .speed_limit(speed_limit_r), .speed_step(speed_step_r),
    .time_step(time_step_r), .start_x(start_x_r), .start_y(start_y_r),
    .start_heading(start_heading_r),
    .out_pos_x, .out_pos_y, .out_speed_now, .out_heading_now,
    .out_mode_now, .out_elapsed
  );
endmodule
`default_nettype wire

// ===== tb/sv/tb_kinematic_heading_speed_integrator_core.sv =====
// Testbench for the kinematic heading and speed integrator: random ticks checked against a predictor.
`default_nettype none
module tb_kinematic_heading_speed_integrator_core;
  timeunit 1ns;
  timeprecision 1ps;
  import khsi_pkg::*;

  localparam logic [2:0] MODE_RSVD_A = 3'd5;
  localparam logic [2:0] MODE_RSVD_B = 3'd6;
  localparam logic [2:0] MODE_RSVD_C = 3'd7;
  localparam int TRIG_FRAC = 16;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct {
    logic        restart;
    logic        has_command;
    logic [2:0]  mode;
    logic [15:0] turn_rate;
  } tick_t;

  typedef struct {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [23:0] speed;
    logic [15:0] heading;
    logic [2:0]  mode;
    logic [31:0] elapsed;
  } telemetry_t;

  class kinematics_scoreboard;
    logic [23:0] speed_limit, speed_step;
    logic [15:0] time_step, start_heading;
    logic [31:0] start_x, start_y;
    logic [31:0] pos_x, pos_y, elapsed;
    logic [23:0] speed;
    logic [15:0] heading;
    logic [2:0]  mode;
    logic signed [15:0] turn_rate;
    telemetry_t  pending_records[$];
    int          errors;
    longint      atan_tab[28];

    function new();
      atan_tab = '{64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
                   64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
                   64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
                   64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
                   64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
                   64'h00000014, 64'h0000000A, 64'h00000005};
      speed_limit = 24'd655360;
      speed_step = 24'd655;
      time_step = 16'd655;
      start_x = '0;
      start_y = '0;
      start_heading = '0;
      pos_x = '0;
      pos_y = '0;
      speed = speed_limit;
      heading = '0;
      mode = MODE_MOVING;
      turn_rate = '0;
      elapsed = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] value);
      case (idx)
        REG_SPEED_LIMIT:   speed_limit = value[23:0];
        REG_SPEED_STEP:    speed_step = value[23:0];
        REG_TIME_STEP:     time_step = value[15:0];
        REG_START_X:       start_x = value;
        REG_START_Y:       start_y = value;
        REG_START_HEADING: start_heading = value[15:0];
        default: ;
      endcase
    endfunction

    function longint round_shr(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    // CORDIC on the heading as a 32-bit angle; the left half-plane is folded by a half turn.
    function void sin_cos(logic [15:0] hdg, output longint c, output longint s);
      logic [31:0] u;
      logic flip;
      longint x, y, z, dx, dy;
      u = {hdg, 16'h0000};
      flip = (u - 32'h4000_0000) < 32'h8000_0000;
      if (flip) u = u - 32'h8000_0000;
      z = longint'(signed'(u));
      x = 652032874;
      y = 0;
      for (int i = 0; i < 28; i++) begin
        dx = x >>> i;
        dy = y >>> i;
        if (z >= 0) begin
          x = x - dy; y = y + dx; z = z - atan_tab[i];
        end else begin
          x = x + dy; y = y - dx; z = z + atan_tab[i];
        end
      end
      if (flip) begin
        x = -x; y = -y;
      end
      c = round_shr(x, 30 - TRIG_FRAC);
      s = round_shr(y, 30 - TRIG_FRAC);
    endfunction

    function void note_tick(tick_t t);
      longint c, s, v, p;
      logic [32:0] e;
      logic [24:0] ns;
      telemetry_t r;
      if (t.restart) begin
        pos_x = start_x;
        pos_y = start_y;
        heading = start_heading;
        speed = speed_limit;
        mode = MODE_MOVING;
        elapsed = '0;
      end else begin
        if (t.has_command) begin
          mode = (t.mode <= MODE_MOVING) ? t.mode : MODE_STOPPED;
          turn_rate = t.turn_rate;
        end
        if (mode == MODE_TURNING || mode == MODE_MOVING) begin
          p = longint'(turn_rate) * longint'(time_step) + 32768;
          heading = heading + p[31:16];
        end else if (mode == MODE_ACCEL) begin
          ns = speed + speed_step;
          speed = (ns > speed_limit) ? speed_limit : ns[23:0];
        end else if (mode == MODE_DECEL) begin
          speed = (speed < speed_step) ? 24'd0 : speed - speed_step;
        end
        sin_cos(heading, c, s);
        v = round_shr(longint'(speed) * longint'(time_step), 16);
        pos_x = pos_x + 32'(round_shr(c * v, TRIG_FRAC));
        pos_y = pos_y + 32'(round_shr(s * v, TRIG_FRAC));
        e = elapsed + time_step;
        elapsed = e[32] ? 32'hFFFF_FFFF : e[31:0];
      end
      r.pos_x = pos_x;
      r.pos_y = pos_y;
      r.speed = speed;
      r.heading = heading;
      r.mode = mode;
      r.elapsed = elapsed;
      pending_records.push_back(r);
    endfunction

    function void check_record(telemetry_t a);
      telemetry_t x;
      if (pending_records.size() == 0) begin
        $error("telemetry record with no tick outstanding");
        errors++;
        return;
      end
      x = pending_records.pop_front();
      if (a.pos_x !== x.pos_x) begin
        $error("pos_x expected %h actual %h", x.pos_x, a.pos_x); errors++;
      end
      if (a.pos_y !== x.pos_y) begin
        $error("pos_y expected %h actual %h", x.pos_y, a.pos_y); errors++;
      end
      if (a.speed !== x.speed) begin
        $error("speed_now expected %h actual %h", x.speed, a.speed); errors++;
      end
      if (a.heading !== x.heading) begin
        $error("heading_now expected %h actual %h", x.heading, a.heading); errors++;
      end
      if (a.mode !== x.mode) begin
        $error("mode_now expected %h actual %h", x.mode, a.mode); errors++;
      end
      if (a.elapsed !== x.elapsed) begin
        $error("elapsed expected %h actual %h", x.elapsed, a.elapsed); errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, in_ready;
  logic in_restart = 1'b0, in_has_command = 1'b0;
  logic [2:0] in_mode = MODE_STOPPED;
  logic signed [15:0] in_turn_rate = '0;
  logic out_valid, out_ready = 1'b0;
  logic signed [31:0] out_pos_x, out_pos_y;
  logic [23:0] out_speed_now;
  logic [15:0] out_heading_now;
  logic [2:0] out_mode_now;
  logic [31:0] out_elapsed;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [4:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0, cfg_prdata;
  logic cfg_pready;

  kinematics_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int cycles = 0;

  kinematic_heading_speed_integrator_core dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_kinematic_heading_speed_integrator_core: done, errors");
      $finish;
    end
  end

  always @(negedge clk)
    out_ready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    telemetry_t a;
    if (rst_n && out_valid && out_ready) begin
      a.pos_x = out_pos_x;
      a.pos_y = out_pos_y;
      a.speed = out_speed_now;
      a.heading = out_heading_now;
      a.mode = out_mode_now;
      a.elapsed = out_elapsed;
      sb.check_record(a);
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.write_reg(idx, value);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  // Called at a falling edge; leaves the caller at a falling edge.
  task automatic send_tick(logic rs, logic hc, logic [2:0] md, logic [15:0] tr);
    tick_t t;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_restart <= rs;
    in_has_command <= hc;
    in_mode <= md;
    in_turn_rate <= tr;
    do @(posedge clk); while (!in_ready);
    t.restart = rs;
    t.has_command = hc;
    t.mode = md;
    t.turn_rate = tr;
    sb.note_tick(t);
    @(negedge clk);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_records.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic random_ticks(int n);
    logic [2:0] md;
    for (int k = 0; k < n; k++) begin
      md = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
      send_tick($urandom_range(29) == 0, $urandom_range(2) == 0, md, 16'($urandom));
    end
  endtask

  task automatic configure(logic [23:0] lim, logic [23:0] stp, logic [15:0] ts,
                           logic [31:0] sx, logic [31:0] sy, logic [15:0] sh);
    write_reg(REG_SPEED_LIMIT, 32'(lim));
    write_reg(REG_SPEED_STEP, 32'(stp));
    write_reg(REG_TIME_STEP, 32'(ts));
    write_reg(REG_START_X, sx);
    write_reg(REG_START_Y, sy);
    write_reg(REG_START_HEADING, 32'(sh));
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Default registers: every mode, reserved modes, turn rate extremes, restart.
    send_tick(1'b0, 1'b0, MODE_STOPPED, 16'h0000);
    send_tick(1'b0, 1'b1, MODE_TURNING, 16'h7FFF);
    send_tick(1'b0, 1'b0, MODE_TURNING, 16'h0000);
    send_tick(1'b0, 1'b1, MODE_MOVING, 16'h8000);
    send_tick(1'b0, 1'b1, MODE_ACCEL, 16'hFFFF);
    send_tick(1'b0, 1'b1, MODE_DECEL, 16'h0001);
    send_tick(1'b0, 1'b1, MODE_STOPPED, 16'h1234);
    send_tick(1'b0, 1'b1, MODE_RSVD_A, 16'h4000);
    send_tick(1'b0, 1'b1, MODE_RSVD_B, 16'hC000);
    send_tick(1'b0, 1'b1, MODE_RSVD_C, 16'h7FFF);
    send_tick(1'b1, 1'b1, MODE_TURNING, 16'h7FFF);
    send_tick(1'b0, 1'b0, MODE_STOPPED, 16'h0000);
    settle();

    // Large speed step: accelerate to the limit, decelerate to zero.
    configure(24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF);
    send_tick(1'b1, 1'b0, MODE_STOPPED, 16'h0000);
    send_tick(1'b0, 1'b1, MODE_ACCEL, 16'h0000);
    send_tick(1'b0, 1'b1, MODE_DECEL, 16'h0000);
    send_tick(1'b0, 1'b1, MODE_DECEL, 16'h0000);
    send_tick(1'b0, 1'b1, MODE_ACCEL, 16'h0000);
    send_tick(1'b0, 1'b1, MODE_MOVING, 16'h8000);
    send_tick(1'b0, 1'b1, MODE_TURNING, 16'h7FFF);

    for (int ph = 0; ph < 7; ph++) begin
      send_idle_pct = (ph % 4 == 1 || ph % 4 == 3) ? ((ph % 4 == 1) ? 45 : 24) : 0;
      recv_stall_pct = (ph % 4 == 2) ? 45 : ((ph % 4 == 3) ? 24 : 0);
      random_ticks(260);
      settle();
      case (ph)
        0: configure(24'd0, 24'd0, 16'd1, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0000);
        1: configure(24'($urandom), 24'($urandom_range(5000)), 16'($urandom),
                     $urandom, $urandom, 16'($urandom));
        // A zero tick length freezes motion and elapsed time.
        2: configure(24'd655360, 24'd3000, 16'd0, $urandom, $urandom, 16'($urandom));
        3: configure(24'hFFFFFF, 24'($urandom_range(200000)), 16'hFFFF,
                     $urandom, $urandom, 16'h8000);
        // Lowered limit while the speed is still high from the previous phase.
        4: begin
          write_reg(REG_SPEED_LIMIT, 32'd1000);
          write_reg(REG_TIME_STEP, 32'($urandom_range(65535, 1)));
        end
        5: configure(24'($urandom), 24'($urandom), 16'($urandom_range(65535, 1)),
                     $urandom, $urandom, 16'($urandom));
        default: ;
      endcase
    end

    while (sb.pending_records.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (sb.errors == 0) begin
      $display("tb_kinematic_heading_speed_integrator_core: done, clean");
    end else begin
      $display("tb_kinematic_heading_speed_integrator_core: done, errors");
    end
    $finish;
  end
endmodule
`default_nettype wire
